// ----- rtl/gtpq_pkg.sv -----
// gtpq_pkg: types, codes and defaults shared by the playout queue modules.
// No dependencies.
package gtpq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int GEN_W    = 32;
   localparam int TIME_W   = 48;
   localparam int HANDLE_W = 16;
   localparam int AGE_W    = 32;
   localparam int CNT5_W   = 5;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Word index of the age limit register on the csr port
   localparam logic CSR_IDX_MAX_AGE = 1'b0;

   // Request kinds
   localparam logic [2:0] OP_OPEN    = 3'd0;
   localparam logic [2:0] OP_ADVANCE = 3'd1;
   localparam logic [2:0] OP_CLOSE   = 3'd2;
   localparam logic [2:0] OP_PUSH    = 3'd3;
   localparam logic [2:0] OP_POP     = 3'd4;

   // Result status codes
   localparam logic [2:0] STAT_ACCEPTED = 3'd0;
   localparam logic [2:0] STAT_REPLACED = 3'd1;
   localparam logic [2:0] STAT_CLOSED   = 3'd2;
   localparam logic [2:0] STAT_STALE    = 3'd3;
   localparam logic [2:0] STAT_FRAME    = 3'd4;
   localparam logic [2:0] STAT_NONE     = 3'd5;
   localparam logic [2:0] STAT_DONE     = 3'd6;

   typedef struct packed {
      logic [GEN_W-1:0]    generation;
      logic [TIME_W-1:0]   arrival;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ----- rtl/gtpq_store.sv -----
// gtpq_store: descriptor memory of the playout queue, one write and one
// registered read port. Depends on gtpq_pkg.
module gtpq_store
   import gtpq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gtpq_age_check.sv -----
// gtpq_age_check: shared expiry compare, used once per examined entry.
// Depends on gtpq_pkg.
module gtpq_age_check
   import gtpq_pkg::*;
(
   input  logic              enable,
   input  logic [TIME_W-1:0] now_us,
   input  logic [TIME_W-1:0] arrival_us,
   input  logic [AGE_W-1:0]  max_age_us,
   output logic              expired
);

   logic [TIME_W:0] diff;

   // diff[TIME_W] is the borrow: set when the arrival lies in the future
   assign diff = {1'b0, now_us} - {1'b0, arrival_us};

   assign expired = enable && (max_age_us != '0) && !diff[TIME_W] &&
                    (diff[TIME_W-1:0] > {{(TIME_W-AGE_W){1'b0}}, max_age_us});

endmodule

// ----- rtl/generation_tagged_playout_queue.sv -----
// generation_tagged_playout_queue: drop-oldest descriptor queue with generation tag.
// Depends on gtpq_pkg, gtpq_store and gtpq_age_check.
// Sequence: a request is captured in S_IDLE, executed in S_EXEC and its result
// registered in S_DONE once the output is free; a pop adds S_POP_RD (memory read) and
// S_POP_EV (evaluation) per examined entry. Requests are taken only in S_IDLE.
// Reset: queue closed and empty, generation and max_age_us zero; the entry
// memory is not cleared and needs no clearing pass.
module generation_tagged_playout_queue
   import gtpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: generation[31:0], time_us[79:32], payload_handle[95:80],
   //            use_age_limit[96], zero[103:97]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,   // req_type[2:0]
   // rsp_tdata: out_generation[31:0], out_arrival_us[79:32],
   //            out_payload_handle[95:80], aged_out_count[100:96],
   //            fill_level[105:101], zero[111:106]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,   // status[2:0]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = PW + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_POP_RD = 5'b00100,
      S_POP_EV = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // captured request
   logic [2:0]          op_ff, op_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                use_age_ff, use_age_in;

   // queue state
   logic [PW-1:0]    rp_ff, rp_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [GEN_W-1:0] cur_gen_ff, cur_gen_in;
   logic             open_ff, open_in;
   logic [AGE_W-1:0] max_age_ff, max_age_in;

   // result under construction
   logic [2:0]          res_status_ff, res_status_in;
   logic [GEN_W-1:0]    res_gen_ff, res_gen_in;
   logic [TIME_W-1:0]   res_arr_ff, res_arr_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [CNT5_W-1:0]   res_exp_ff, res_exp_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]            rsp_user_ff, rsp_user_in;

   logic            req_accept;
   logic            csr_write;
   logic            wr_en;
   logic [PW-1:0]   wr_addr;
   entry_type       wr_data;
   entry_type       rd_data;
   logic            age_expired;
   logic [SW-1:0]   slot_sum;
   logic [PW-1:0]   tail_slot;
   logic            out_free;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   gtpq_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   gtpq_age_check u_age (
      .enable     (use_age_ff),
      .now_us     (time_ff),
      .arrival_us (rd_data.arrival),
      .max_age_us (max_age_ff),
      .expired    (age_expired)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_AGE) ? max_age_ff : '0;

   // tail slot for a non-full queue: (rp + count) mod CAPACITY, sum < 2*CAPACITY
   assign slot_sum  = SW'(rp_ff) + SW'(count_ff);
   assign tail_slot = (slot_sum >= SW'(CAPACITY)) ? PW'(slot_sum - SW'(CAPACITY))
                                                   : PW'(slot_sum);

   assign wr_data.generation = gen_ff;
   assign wr_data.arrival    = time_ff;
   assign wr_data.handle     = handle_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      gen_in        = gen_ff;
      time_in       = time_ff;
      handle_in     = handle_ff;
      use_age_in    = use_age_ff;
      rp_in         = rp_ff;
      count_in      = count_ff;
      cur_gen_in    = cur_gen_ff;
      open_in       = open_ff;
      max_age_in    = max_age_ff;
      res_status_in = res_status_ff;
      res_gen_in    = res_gen_ff;
      res_arr_in    = res_arr_ff;
      res_handle_in = res_handle_ff;
      res_exp_in    = res_exp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_slot;

      if (csr_write && csr_paddr[2] == CSR_IDX_MAX_AGE) begin
         max_age_in = csr_pwdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in      = req_tuser;
               gen_in     = req_tdata[31:0];
               time_in    = req_tdata[79:32];
               handle_in  = req_tdata[95:80];
               use_age_in = req_tdata[96];
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = STAT_DONE;
            res_gen_in    = '0;
            res_arr_in    = '0;
            res_handle_in = '0;
            res_exp_in    = '0;
            state_in      = S_DONE;
            case (op_ff)
               OP_OPEN: begin
                  rp_in      = '0;
                  count_in   = '0;
                  cur_gen_in = gen_ff;
                  open_in    = (gen_ff != '0);
               end
               OP_ADVANCE: begin
                  if (open_ff && gen_ff > cur_gen_ff) begin
                     rp_in      = '0;
                     count_in   = '0;
                     cur_gen_in = gen_ff;
                  end
               end
               OP_CLOSE: begin
                  rp_in      = '0;
                  count_in   = '0;
                  cur_gen_in = '0;
                  open_in    = 1'b0;
               end
               OP_PUSH: begin
                  if (!open_ff) begin
                     res_status_in = STAT_CLOSED;
                  end else if (gen_ff != cur_gen_ff) begin
                     res_status_in = STAT_STALE;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     // full: overwrite the head slot and move the head on
                     res_status_in = STAT_REPLACED;
                     wr_en         = 1'b1;
                     wr_addr       = rp_ff;
                     rp_in         = ptr_next(rp_ff);
                  end else begin
                     res_status_in = STAT_ACCEPTED;
                     wr_en         = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
               OP_POP: begin
                  res_status_in = STAT_NONE;
                  if (open_ff && count_ff != '0) begin
                     state_in = S_POP_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP_RD: begin
            state_in = S_POP_EV;
         end
         S_POP_EV: begin
            rp_in    = ptr_next(rp_ff);
            count_in = count_ff - 1'b1;
            if (rd_data.generation == cur_gen_ff && !age_expired) begin
               res_status_in = STAT_FRAME;
               res_gen_in    = rd_data.generation;
               res_arr_in    = rd_data.arrival;
               res_handle_in = rd_data.handle;
               state_in      = S_DONE;
            end else begin
               if (rd_data.generation == cur_gen_ff) begin
                  res_exp_in = res_exp_ff + 1'b1;
               end
               if (count_ff == CW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_POP_RD;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {6'b0, CNT5_W'(count_ff), res_exp_ff, res_handle_ff,
                               res_arr_ff, res_gen_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         count_ff     <= '0;
         cur_gen_ff   <= '0;
         open_ff      <= 1'b0;
         max_age_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         cur_gen_ff   <= cur_gen_in;
         open_ff      <= open_in;
         max_age_ff   <= max_age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      gen_ff        <= gen_in;
      time_ff       <= time_in;
      handle_ff     <= handle_in;
      use_age_ff    <= use_age_in;
      res_status_ff <= res_status_in;
      res_gen_ff    <= res_gen_in;
      res_arr_ff    <= res_arr_in;
      res_handle_ff <= res_handle_in;
      res_exp_ff    <= res_exp_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
